[rtl/core/fixed_point_cosine_assert.svh]
// ----------------------------------------------------------------------------
// Fixed-point cosine assertion macros
// Concurrent check macros for the cosine pipeline; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_COSINE_ASSERT_SVH
`define FIXED_POINT_COSINE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define COS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("cosine pipeline check failed");
// Next-cycle implication, disabled during reset.
`define COS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("cosine pipeline check failed");
`else
`define COS_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define COS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

[rtl/core/cos_pkg.sv]
// ----------------------------------------------------------------------------
// Cosine package
// Constants and the rounded unsigned multiply shared by the pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cos_pkg;

    // 1.0 in 0.15 format.
    localparam logic [15:0] OneQ15     = 16'h8000;
    // 0.23361 in 0.16 format.
    localparam logic [15:0] LinCoefQ16 = 16'd15310;
    // 0.019531 in 0.17 format; only its high byte takes part.
    localparam logic [15:0] SqCoefQ17  = 16'd2560;
    localparam logic [7:0]  SqCoefHi   = SqCoefQ17[15:8];

    // Unsigned 0.16 product rounded to nearest, ties up, kept to 16 bits.
    function automatic logic [15:0] umul_round16(input logic [15:0] a,
                                                 input logic [15:0] b);
        logic [31:0] prod;
        logic [31:0] rnd;
        begin
            prod = {16'd0, a} * {16'd0, b};
            rnd  = prod + 32'h0000_8000;
            umul_round16 = rnd[31:16];
        end
    endfunction

endpackage

[rtl/core/cos_front.sv]
// ----------------------------------------------------------------------------
// Cosine front end
// Folds the angle into a 0.15 fraction and squares it, in two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cos_front import cos_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] angle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] u,
    output logic        neg
);

    logic        v1_reg;
    logic [15:0] f_reg;
    logic [15:0] f_next;
    logic        neg1_reg;
    logic        v2_reg;
    logic [15:0] u_reg;
    logic [15:0] u_next;
    logic        neg2_reg;
    logic        adv1;
    logic        adv2;
    logic [1:0]  quad;
    logic [15:0] sq;

    assign adv2     = !v2_reg || !out_stall;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    // Odd quadrants mirror the fraction about 1.0.
    assign quad = angle[15:14];
    always_comb
    begin
        f_next = {1'b0, angle[13:0], 1'b0};
        if (quad[0])
        begin
            f_next = OneQ15 - f_next;
        end
    end

    assign sq     = umul_round16(f_reg, f_reg);
    assign u_next = {sq[14:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            f_reg    <= f_next;
            neg1_reg <= quad[0] ^ quad[1];
        end
        if (adv2 && v1_reg)
        begin
            u_reg    <= u_next;
            neg2_reg <= neg1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign u         = u_reg;
    assign neg       = neg2_reg;

endmodule

[rtl/core/cos_poly.sv]
// ----------------------------------------------------------------------------
// Cosine polynomial
// Evaluates (1 - u) * (1 - u * (a - b * u)) over three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cos_poly import cos_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] u,
    input  logic        neg,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] mag,
    output logic        out_neg
);

    logic        v3_reg;
    logic [15:0] y3_reg;
    logic [15:0] s1_reg;
    logic [15:0] u3_reg;
    logic        neg3_reg;
    logic        v4_reg;
    logic [15:0] y4_reg;
    logic [15:0] s2_reg;
    logic        neg4_reg;
    logic        v5_reg;
    logic [15:0] s3_reg;
    logic        neg5_reg;
    logic        adv3;
    logic        adv4;
    logic        adv5;
    logic [15:0] hb;
    logic [15:0] s1_next;
    logic [15:0] s2_next;
    logic [15:0] s3_next;

    assign adv5     = !v5_reg || !out_stall;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign in_stall = !adv3;

    // Quadratic coefficient uses the high bytes only.
    assign hb      = {8'd0, SqCoefHi} * {8'd0, u[15:8]};
    assign s1_next = LinCoefQ16 - hb;
    assign s2_next = OneQ15 - umul_round16(u3_reg, s1_reg);
    assign s3_next = umul_round16(y4_reg, s2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv3)
            begin
                v3_reg <= in_valid;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
            if (adv5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && in_valid)
        begin
            y3_reg   <= OneQ15 - u;
            s1_reg   <= s1_next;
            u3_reg   <= u;
            neg3_reg <= neg;
        end
        if (adv4 && v3_reg)
        begin
            y4_reg   <= y3_reg;
            s2_reg   <= s2_next;
            neg4_reg <= neg3_reg;
        end
        if (adv5 && v4_reg)
        begin
            s3_reg   <= s3_next;
            neg5_reg <= neg4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign mag       = s3_reg;
    assign out_neg   = neg5_reg;

endmodule

[rtl/core/fixed_point_cosine.sv]
// Throughput: one word per cycle when not stalled; the six stages each hold a word.
// The rate is set by the stage chain: a stage loads whenever it is empty or
// the stage after it moves, so a stall at the output only backs up full stages.
// Reset (rst_n, asynchronous, active low) clears every stage valid bit only.
// ----------------------------------------------------------------------------
// Fixed-point cosine
// Cosine of a 16-bit angle (65536 units per turn), scaled by 2^14.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fixed_point_cosine_assert.svh"

module fixed_point_cosine import cos_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               angle_valid,
    output logic               angle_stall,
    input  logic [15:0]        angle,
    output logic               cosine_valid,
    input  logic               cosine_stall,
    output logic signed [15:0] cosine
);

    // Front end: stage 1 folds the angle into the first quadrant as a
    // 0.15 fraction, stage 2 squares it into u.
    logic        fr_valid;
    logic        fr_stall;
    logic [15:0] fr_u;
    logic        fr_neg;

    // Polynomial: stages 3 to 5 build the magnitude of the cosine in 0.14.
    logic        po_valid;
    logic        po_stall;
    logic [15:0] po_mag;
    logic        po_neg;

    // Stage 6 is the output register, which applies the quadrant sign.
    logic        out_valid_reg;
    logic [15:0] cosine_reg;
    logic [15:0] cosine_next;
    logic        adv6;

    cos_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (angle_valid),
        .in_stall  (angle_stall),
        .angle     (angle),
        .out_valid (fr_valid),
        .out_stall (fr_stall),
        .u         (fr_u),
        .neg       (fr_neg)
    );

    cos_poly u_poly
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_stall  (fr_stall),
        .u         (fr_u),
        .neg       (fr_neg),
        .out_valid (po_valid),
        .out_stall (po_stall),
        .mag       (po_mag),
        .out_neg   (po_neg)
    );

    // The output register takes a new word when it is empty or its word is
    // being taken in this cycle.
    assign adv6     = !out_valid_reg || !cosine_stall;
    assign po_stall = !adv6;

    // Quadrants 1 and 2 give a negative cosine.
    assign cosine_next = po_neg ? (~po_mag + 16'd1) : po_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv6)
        begin
            out_valid_reg <= po_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv6 && po_valid)
        begin
            cosine_reg <= cosine_next;
        end
    end

    assign cosine_valid = out_valid_reg;
    assign cosine       = $signed(cosine_reg);

    // A valid cosine always lies within plus and minus one.
    `COS_ASSERT_IMPL(a_cos_high, clk, rst_n, cosine_valid, cosine <= 16'sd16384)
    `COS_ASSERT_IMPL(a_cos_low, clk, rst_n, cosine_valid, cosine >= -16'sd16384)
    // The input can only be held off when the output register is full.
    `COS_ASSERT_IMPL(a_stall_needs_full, clk, rst_n, angle_stall, cosine_valid && cosine_stall)
    // A word that is stalled at the output is not dropped.
    `COS_ASSERT_NEXT(a_out_kept, clk, rst_n, cosine_valid && cosine_stall, cosine_valid)

endmodule
